// ----- src/srgbtc_pkg.sv -----
// Package: sizes, types and the knot tables of the sRGB transfer converter.
package srgbtc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TABLE_BITS  = 8;
   localparam int FRAC_BITS   = SAMPLE_BITS - TABLE_BITS;
   localparam int FRAC_W      = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int SEGS        = 1 << TABLE_BITS;
   localparam int KNOTS       = SEGS + 1;
   localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
   localparam int ROOT_P      = 32;

   typedef logic [511:0] big_type;
   typedef logic [KNOTS-1:0][SAMPLE_BITS-1:0] knot_table_type;

   // control handed from the table read stage to the interpolator
   typedef struct packed {
      logic              valid;
      logic [FRAC_W-1:0] frac;
   } srgbtc_stage_type;

   localparam big_type SEGS_BIG    = big_type'(SEGS);
   localparam big_type FS_BIG      = big_type'(FULL_SCALE);
   localparam big_type ENC_TOE_DIV = 200 * SEGS_BIG;
   localparam big_type DEC_TOE_DIV = 2584 * SEGS_BIG;
   localparam big_type ONE_P       = big_type'(1) << ROOT_P;

   function automatic logic [SAMPLE_BITS-1:0] sat_fs(input big_type v);
      return (v > FS_BIG) ? SAMPLE_BITS'(FULL_SCALE) : v[SAMPLE_BITS-1:0];
   endfunction

   // largest t in [0, 2^32] with t^pe * scale <= target
   function automatic big_type big_root(input big_type target, input int pe,
                                        input big_type scale);
      big_type lo;
      big_type hi;
      big_type mid;
      big_type p;
      lo = '0;
      hi = ONE_P;
      for (int s = 0; s < 34; s++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            p = scale;
            for (int j = 0; j < pe; j++) begin
               p = p * mid;
            end
            if (p <= target) lo = mid;
            else hi = mid - 1;
         end
      end
      return lo;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] encode_knot(input int k);
      big_type kb;
      big_type tg;
      big_type t;
      big_type num;
      big_type nh;
      big_type nl;
      kb = big_type'(k);
      if (kb * 10000000 <= 31308 * SEGS_BIG) begin
         return sat_fs((2 * 1292 * kb * FS_BIG + 100 * SEGS_BIG) / ENC_TOE_DIV);
      end
      tg = kb * kb * kb * kb * kb;
      tg = tg << (12 * ROOT_P - 5 * TABLE_BITS);
      t = big_root(tg, 12, big_type'(1));
      if (1055 * t < 55 * ONE_P) return '0;
      num = 1055 * t - 55 * ONE_P;
      nh  = num >> 32;
      nl  = num & big_type'(32'hFFFF_FFFF);
      return sat_fs((nh * FS_BIG + 500 + ((nl * FS_BIG) >> 32)) / 1000);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] decode_knot(input int k);
      big_type kb;
      big_type n;
      big_type d;
      big_type d12;
      big_type tg;
      big_type t;
      kb = big_type'(k);
      if (kb * 100000 <= 4045 * SEGS_BIG) begin
         return sat_fs((200 * kb * FS_BIG + 1292 * SEGS_BIG) / DEC_TOE_DIV);
      end
      n   = 1000 * kb + 55 * SEGS_BIG;
      d   = 1055 * SEGS_BIG;
      tg  = big_type'(1);
      d12 = big_type'(1);
      for (int j = 0; j < 12; j++) begin
         tg  = tg * n;
         d12 = d12 * d;
      end
      tg = tg << (5 * ROOT_P);
      t = big_root(tg, 5, d12);
      return sat_fs((t * FS_BIG + (ONE_P >> 1)) >> ROOT_P);
   endfunction

   function automatic knot_table_type build_encode();
      knot_table_type tab;
      for (int k = 0; k < KNOTS; k++) begin
         tab[k] = encode_knot(k);
      end
      return tab;
   endfunction

   function automatic knot_table_type build_decode();
      knot_table_type tab;
      for (int k = 0; k < KNOTS; k++) begin
         tab[k] = decode_knot(k);
      end
      return tab;
   endfunction

   localparam knot_table_type ENC_KNOTS = build_encode();
   localparam knot_table_type DEC_KNOTS = build_decode();

endpackage

// ----- src/srgbtc_knot_rom.sv -----
// Knot ROM: both curve tables, two registered read ports (knot i and i+1).
module srgbtc_knot_rom (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic                             dir,
   input  logic [srgbtc_pkg::TABLE_BITS-1:0] index,
   output logic [srgbtc_pkg::SAMPLE_BITS-1:0] knot_a,
   output logic [srgbtc_pkg::SAMPLE_BITS-1:0] knot_b
);
   import srgbtc_pkg::*;

   logic [TABLE_BITS:0]      addr_a;
   logic [TABLE_BITS:0]      addr_b;
   logic [SAMPLE_BITS-1:0]   knot_a_ff;
   logic [SAMPLE_BITS-1:0]   knot_b_ff;

   assign addr_a = {1'b0, index};
   assign addr_b = addr_a + 1'b1;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         knot_a_ff <= dir ? DEC_KNOTS[addr_a] : ENC_KNOTS[addr_a];
         knot_b_ff <= dir ? DEC_KNOTS[addr_b] : ENC_KNOTS[addr_b];
      end
   end

   assign knot_a = knot_a_ff;
   assign knot_b = knot_b_ff;

endmodule

// ----- src/srgbtc_interp.sv -----
// Interpolator: a + r*(b-a), rounded half up, registered with its strobe.
module srgbtc_interp (
   input  logic                               clock,
   input  logic                               reset,
   input  srgbtc_pkg::srgbtc_stage_type       stage,
   input  logic [srgbtc_pkg::SAMPLE_BITS-1:0] knot_a,
   input  logic [srgbtc_pkg::SAMPLE_BITS-1:0] knot_b,
   output logic                               out_valid,
   output logic [srgbtc_pkg::SAMPLE_BITS-1:0] out_sample
);
   import srgbtc_pkg::*;

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int ACC_W  = SAMPLE_BITS + FRAC_W + 2;
   localparam logic signed [ACC_W-1:0] HALF =
      (FRAC_BITS == 0) ? '0 : (ACC_W'(1) <<< (FRAC_W - 1));

   logic signed [DIFF_W-1:0]   diff;
   logic signed [FRAC_W:0]     frac_s;
   logic signed [ACC_W-1:0]    prod;
   logic signed [ACC_W-1:0]    base;
   logic signed [ACC_W-1:0]    acc;
   logic                       valid_ff;
   logic [SAMPLE_BITS-1:0]     sample_ff;
   logic [SAMPLE_BITS-1:0]     sample_in;

   assign diff   = $signed({1'b0, knot_b}) - $signed({1'b0, knot_a});
   assign frac_s = $signed({1'b0, stage.frac});
   assign prod   = ACC_W'(diff) * ACC_W'(frac_s);
   assign base   = $signed(ACC_W'({1'b0, knot_a}) << FRAC_BITS);
   assign acc    = base + prod + HALF;
   assign sample_in = acc[FRAC_BITS +: SAMPLE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage.valid) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

endmodule

// ----- src/srgb_transfer_convert.sv -----
// Top level: sRGB transfer curve converter (table plus linear interpolation).
//
// Use:
//   Input: drive req_sample_in and raise start; the item is taken at a rising
//   edge with start high and busy low. busy is low whenever reset is low, so
//   an item can be taken every cycle.
//   Output: rsp_valid is high for exactly one cycle with rsp_sample_out, once
//   the item has passed the knot ROM and output registers; items come out in order.
//   Throughput: one item per cycle. The item passes the registered knot ROM
//   read (both neighbors fetched on two ports), then the interpolation
//   multiply and output register.
//   Configuration: csr_write_en with csr_write_data sets direction
//   (0 encodes linear to sRGB, 1 decodes). It is sampled when an item is
//   taken; write it only while no item is in flight.
//   Reset: synchronous, active high. Clears direction to encode and drops
//   all items in flight; busy is high during reset.
//   The receiver cannot stall: each result is shown for one cycle only.
module srgb_transfer_convert (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [srgbtc_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                               rsp_valid,
   output logic [srgbtc_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                               csr_write_en,
   input  logic                               csr_write_data
);
   import srgbtc_pkg::*;

   logic                   accept;
   logic                   direction_ff;
   logic                   direction_in;
   srgbtc_stage_type       stage_ff;
   srgbtc_stage_type       stage_in;
   logic [SAMPLE_BITS-1:0] knot_a;
   logic [SAMPLE_BITS-1:0] knot_b;

   // never backpressured outside reset: the pipe moves every cycle
   assign busy   = reset;
   assign accept = start && !busy;

   assign direction_in = csr_write_en ? csr_write_data : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
      end
   end

   // knot index is the top bits; the low bits weight the upper neighbor
   always_comb begin
      stage_in.valid = accept;
      stage_in.frac  = (FRAC_BITS == 0) ? '0 : req_sample_in[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
         if (accept) begin
            stage_ff.frac <= stage_in.frac;
         end
      end
   end

   srgbtc_knot_rom u_rom (
      .clock  (clock),
      .rd_en  (accept),
      .dir    (direction_ff),
      .index  (req_sample_in[SAMPLE_BITS-1 -: TABLE_BITS]),
      .knot_a (knot_a),
      .knot_b (knot_b)
   );

   srgbtc_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage_ff),
      .knot_a     (knot_a),
      .knot_b     (knot_b),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample_out)
   );

   // each taken item gives exactly one strobe, after the knot ROM and output registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept, 2))
      else $error("result strobe does not match an item taken two cycles before");

   // on a knot exactly, the output is the knot value itself
   a_on_knot: assert property (@(posedge clock) disable iff (reset)
      (stage_ff.valid && stage_ff.frac == '0) |=> (rsp_sample_out == $past(knot_a)))
      else $error("result on a knot differs from the knot value");

   // direction moves only on a write
   a_dir_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write_en |=> $stable(direction_ff))
      else $error("direction changed without a write");

endmodule
